### src/lruct_pkg.sv
// Shared types and codes for the LRU expiring cache table.
// Used by the controller, the datapath and the top level.
package lruct_pkg;

  // Request codes on req_type
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_TOUCH  = 2'd1;
  localparam logic [1:0] REQ_INSERT = 2'd2;
  localparam logic [1:0] REQ_REMOVE = 2'd3;

  // One table entry as stored in the entry RAM
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] expires;
    logic        expires_valid;
    logic [31:0] modified;
    logic        modified_valid;
    logic [31:0] access;
  } entry_t;

  // How the result of a request is formed
  typedef enum logic [1:0] {
    FIN_HIT,
    FIN_MISS,
    FIN_WRITE,
    FIN_REMOVE
  } fin_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;      // latch the request fields
    logic      ptr_zero;
    logic      ptr_slot;
    logic      ptr_inc;
    logic      rd_en;
    logic      rd_next;   // read at ptr+1 instead of ptr
    logic      save;      // keep the touched entry
    logic      wr_shift;  // move entry ptr+1 down to ptr
    logic      wr_final;  // write the touched or new entry at the end slot
    logic      fin;
    fin_kind_e fin_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       cnt_zero;
    logic       full;
    logic       slot_ok;
    logic       match;
    logic       ptr_last;  // ptr is the last valid entry
    logic       ptr_end;   // ptr equals the end slot
    logic       next_end;  // ptr+1 equals the end slot
  } dp_stat_t;

endpackage

### src/lru_expiring_cache_table_unit.sv
// Top level of the LRU expiring cache table.
// Depends on lruct_pkg, lruct_ctrl, lruct_dp (which holds lruct_ram).

// Table of ENTRIES cached objects in least- to most-recently-used order,
// one request at a time. A request is taken when start is high and busy is
// low; its single result shows for one cycle with result_valid_o high, and
// must be captured then, since the block cannot be stalled. All entries sit
// in one RAM with one read and one write port, so time is set by how many
// entries a request walks: lookup compares valid entries in order until a
// match or the last one, touch shifts the entries above the slot down, insert
// shifts all entries down when evicting, and remove walks none. The result
// shows in the first cycle with busy low again, and a new item can be taken
// in that same cycle.
module lru_expiring_cache_table_unit
  import lruct_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_i,
  input  logic [2:0]  slot_index_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] expires_time_i,
  input  logic        has_expires_i,
  input  logic [31:0] modified_time_i,
  input  logic        has_modified_i,
  input  logic [31:0] date_time_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic        fresh_o,
  output logic [2:0]  found_index_o,
  output logic [31:0] revalidate_time_o,
  output logic [3:0]  fill_level_o,
  output logic        evicted_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lruct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lruct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .key_i             (key_i),
    .slot_index_i      (slot_index_i),
    .now_time_i        (now_time_i),
    .expires_time_i    (expires_time_i),
    .has_expires_i     (has_expires_i),
    .modified_time_i   (modified_time_i),
    .has_modified_i    (has_modified_i),
    .date_time_i       (date_time_i),
    .result_valid_o    (result_valid_o),
    .hit_o             (hit_o),
    .fresh_o           (fresh_o),
    .found_index_o     (found_index_o),
    .revalidate_time_o (revalidate_time_o),
    .fill_level_o      (fill_level_o),
    .evicted_o         (evicted_o)
  );

  // a result only follows a cycle in which an item was in work
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without an item in work");

  // a miss or a write carries no freshness and no revalidation time
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (!fresh_o && revalidate_time_o == '0))
    else $error("fresh or revalidate set without a hit");

  // eviction only when the table stays full
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_o) |-> (fill_level_o == 4'(ENTRIES) && !hit_o))
    else $error("eviction with table not full");

  // fill level never exceeds the table size
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((ENTRIES > 15) || (32'(fill_level_o) <= 32'(ENTRIES))))
    else $error("fill level beyond table size");

endmodule

### src/lruct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lruct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/lruct_ctrl.sv
// Sequencer for the LRU expiring cache table: steps the datapath through
// lookup scans and entry shifts. Depends on lruct_pkg.
module lruct_ctrl
  import lruct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_LK_RD   = 4'd2;
  localparam logic [3:0] S_LK_CMP  = 4'd3;
  localparam logic [3:0] S_TC_RD   = 4'd4;
  localparam logic [3:0] S_TC_SAVE = 4'd5;
  localparam logic [3:0] S_SH_RD   = 4'd6;
  localparam logic [3:0] S_SH_WR   = 4'd7;
  localparam logic [3:0] S_FINAL   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fin_kind = FIN_MISS;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.req)
          REQ_LOOKUP: begin
            if (stat_i.cnt_zero) begin
              cmd_o.fin = 1'b1;
              state_d   = S_IDLE;
            end else begin
              cmd_o.ptr_zero = 1'b1;
              state_d        = S_LK_RD;
            end
          end
          REQ_TOUCH: begin
            if (!stat_i.slot_ok) begin
              cmd_o.fin = 1'b1;
              state_d   = S_IDLE;
            end else begin
              cmd_o.ptr_slot = 1'b1;
              state_d        = S_TC_RD;
            end
          end
          REQ_INSERT: begin
            if (stat_i.full) begin
              // evict: slide everything down one slot first
              cmd_o.ptr_zero = 1'b1;
              state_d        = S_SH_RD;
            end else begin
              state_d = S_FINAL;
            end
          end
          default: begin
            cmd_o.fin      = 1'b1;
            cmd_o.fin_kind = FIN_REMOVE;
            state_d        = S_IDLE;
          end
        endcase
      end
      S_LK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (stat_i.match) begin
          cmd_o.fin      = 1'b1;
          cmd_o.fin_kind = FIN_HIT;
          state_d        = S_IDLE;
        end else if (stat_i.ptr_last) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_LK_RD;
        end
      end
      S_TC_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_TC_SAVE;
      end
      S_TC_SAVE: begin
        cmd_o.save = 1'b1;
        state_d    = stat_i.ptr_end ? S_FINAL : S_SH_RD;
      end
      S_SH_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = stat_i.next_end ? S_FINAL : S_SH_RD;
      end
      S_FINAL: begin
        cmd_o.wr_final = 1'b1;
        cmd_o.fin      = 1'b1;
        cmd_o.fin_kind = FIN_WRITE;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### src/lruct_dp.sv
// Datapath of the LRU expiring cache table: request latch, entry RAM,
// scan pointer, fill count and result registers. Depends on lruct_pkg, lruct_ram.
module lruct_dp
  import lruct_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_i,
  input  logic [2:0]  slot_index_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] expires_time_i,
  input  logic        has_expires_i,
  input  logic [31:0] modified_time_i,
  input  logic        has_modified_i,
  input  logic [31:0] date_time_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic        fresh_o,
  output logic [2:0]  found_index_o,
  output logic [31:0] revalidate_time_o,
  output logic [3:0]  fill_level_o,
  output logic        evicted_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (CW > 3) ? CW : 3;
  localparam int IW = (AW > 3) ? AW : 3;
  localparam int FW = (CW > 4) ? CW : 4;
  localparam int EW = $bits(entry_t);

  // request latch
  logic [1:0]  req_q;
  logic [63:0] key_q;
  logic [2:0]  slot_q;
  logic [31:0] now_q;
  entry_t      new_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  entry_t        saved_q;

  entry_t        rdata;
  entry_t        wdata;
  entry_t        touched;
  logic [AW-1:0] end_ptr;
  logic [AW-1:0] ptr_nxt;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [SW-1:0] slot_w;
  logic [SW-1:0] cnt_w;
  logic          full;
  logic          cnt_zero;

  logic        res_valid_q;
  logic        hit_q;
  logic        fresh_q;
  logic [2:0]  idx_q;
  logic [31:0] reval_q;
  logic [3:0]  fill_q;
  logic        evict_q;

  logic [IW-1:0] idx_ptr_w;
  logic [IW-1:0] idx_end_w;
  logic [FW-1:0] fill_w;
  logic [31:0]   reval_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q                  <= req_type_i;
      key_q                  <= key_i;
      slot_q                 <= slot_index_i;
      now_q                  <= now_time_i;
      new_q.key              <= key_i;
      new_q.expires          <= expires_time_i;
      new_q.expires_valid    <= has_expires_i;
      new_q.modified         <= modified_time_i;
      new_q.modified_valid   <= has_modified_i;
      new_q.access           <= date_time_i;
    end
    if (cmd_i.save) begin
      saved_q <= touched;
    end
  end

  assign cnt_zero = (cnt_q == '0);
  assign full     = (cnt_q >= CW'(ENTRIES));
  assign slot_w   = SW'(slot_q);
  assign cnt_w    = SW'(cnt_q);
  assign ptr_nxt  = ptr_q + AW'(1);

  // last slot that the request writes
  always_comb begin
    if (req_q == REQ_TOUCH) begin
      end_ptr = AW'(cnt_q - CW'(1));
    end else if (full) begin
      end_ptr = AW'(ENTRIES - 1);
    end else begin
      end_ptr = cnt_q[AW-1:0];
    end
  end

  always_comb begin
    touched        = rdata;
    touched.access = now_q;
  end

  assign raddr = cmd_i.rd_next ? ptr_nxt : ptr_q;
  assign waddr = cmd_i.wr_shift ? ptr_q : end_ptr;

  always_comb begin
    if (cmd_i.wr_shift) begin
      wdata = rdata;
    end else if (req_q == REQ_TOUCH) begin
      wdata = saved_q;
    end else begin
      wdata = new_q;
    end
  end

  lruct_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_shift | cmd_i.wr_final),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_zero) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_slot) begin
      ptr_d = slot_w[AW-1:0];
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_nxt;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.fin) begin
      if (cmd_i.fin_kind == FIN_WRITE && req_q == REQ_INSERT && !full) begin
        cnt_d = cnt_q + CW'(1);
      end else if (cmd_i.fin_kind == FIN_REMOVE && !cnt_zero) begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      res_valid_q <= cmd_i.fin;
    end
  end

  always_comb begin
    if (rdata.expires_valid) begin
      reval_w = rdata.expires;
    end else if (rdata.modified_valid) begin
      reval_w = rdata.modified;
    end else begin
      reval_w = rdata.access;
    end
  end

  assign idx_ptr_w = IW'(ptr_q);
  assign idx_end_w = IW'(end_ptr);
  assign fill_w    = FW'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      hit_q   <= 1'b0;
      fresh_q <= 1'b0;
      idx_q   <= '0;
      reval_q <= '0;
      evict_q <= 1'b0;
      fill_q  <= fill_w[3:0];
      case (cmd_i.fin_kind)
        FIN_HIT: begin
          hit_q   <= 1'b1;
          fresh_q <= rdata.expires_valid && (now_q < rdata.expires);
          idx_q   <= idx_ptr_w[2:0];
          reval_q <= reval_w;
        end
        FIN_WRITE: begin
          idx_q   <= idx_end_w[2:0];
          evict_q <= (req_q == REQ_INSERT) && full;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.cnt_zero = cnt_zero;
  assign stat_o.full     = full;
  assign stat_o.slot_ok  = (slot_w < cnt_w);
  assign stat_o.match    = (rdata.key == key_q);
  assign stat_o.ptr_last = (CW'(ptr_q) == (cnt_q - CW'(1)));
  assign stat_o.ptr_end  = (ptr_q == end_ptr);
  assign stat_o.next_end = (ptr_nxt == end_ptr);

  assign result_valid_o    = res_valid_q;
  assign hit_o             = hit_q;
  assign fresh_o           = fresh_q;
  assign found_index_o     = idx_q;
  assign revalidate_time_o = reval_q;
  assign fill_level_o      = fill_q;
  assign evicted_o         = evict_q;

endmodule
